FILE: hw/rtl/uttcp_pkg.sv
// ----------------------------------------------------------------------------
// uttcp_pkg: shared constants for the serial text and time command parser
// Character codes and scan phase codes used by the parser.
// ----------------------------------------------------------------------------
package uttcp_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] phase_t;
  typedef logic [23:0] value_t;

  localparam byte_t CH_LT    = 8'h3C;  // '<'
  localparam byte_t CH_GT    = 8'h3E;  // '>'
  localparam byte_t CH_BANG  = 8'h21;  // '!'
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_COLON = 8'h3A;
  localparam byte_t CH_PLUS  = 8'h2B;
  localparam byte_t CH_MINUS = 8'h2D;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t CH_NINE  = 8'h39;

  // Scan phases are 3*k + kind for field k, then done and fail.
  localparam phase_t PH_LAST_DIGITS = 4'd8;
  localparam phase_t PH_DONE        = 4'd9;
  localparam phase_t PH_FAIL        = 4'd10;
  localparam phase_t PH_HOUR_DIGITS = 4'd2;

  localparam logic [1:0] KIND_SPACE  = 2'd0;
  localparam logic [1:0] KIND_SIGN   = 2'd1;
  localparam logic [1:0] KIND_DIGITS = 2'd2;

  localparam value_t VALUE_MAX   = 24'hFFFFFF;
  localparam value_t HOUR_LIMIT  = 24'd24;
  localparam value_t MINSEC_LIMIT = 24'd60;

endpackage

FILE: hw/rtl/uart_text_and_time_command_parser.sv
// ----------------------------------------------------------------------------
// uart_text_and_time_command_parser: serial command parser with echo
// Echoes every received byte, captures short text messages and scans time
// lines of the form hh:mm:ss.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / in_rx_byte) carries one received
//   byte per request. Every accepted request yields exactly one result on
//   the output channel (out_valid / out_ready and the out_ fields): the echo
//   of the byte, plus a text_done flag with three stored characters when a
//   '>' closes a text capture, or a time_set flag with hours, minutes and
//   seconds when CR/LF ends a valid '!' time line.
//   Result: registered; it appears in the cycle after the request is accepted.
//   Throughput: one byte per cycle unless stalled. The parser state and the
//   result register are updated in the same cycle from one pass of decode
//   logic; the decimal accumulate (value * 10 + digit) is the longest path.
//   Reset: clears both modes, the text store and the scan state; no result
//   is pending afterward.
//   Stall: the result register holds until taken. A new request is still
//   accepted in the cycle the pending result is taken; while the receiver
//   stalls, in_ready stays low.
// ----------------------------------------------------------------------------
module uart_text_and_time_command_parser
  import uttcp_pkg::*;
#(
  parameter int TEXT_LEN      = 3,
  parameter int TIME_LINE_LEN = 11
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_echo_byte,
  output logic       out_text_done,
  output logic [7:0] out_text_char_a,
  output logic [7:0] out_text_char_b,
  output logic [7:0] out_text_char_c,
  output logic       out_time_set,
  output logic [4:0] out_hours,
  output logic [5:0] out_minutes,
  output logic [5:0] out_seconds
);

  localparam int FILL_W  = $clog2(TEXT_LEN + 1);
  localparam int TFILL_W = $clog2(TIME_LINE_LEN + 1);
  localparam int NUM_CHARS = 3;

  // Parser state
  logic               text_active_r, text_active_nxt;
  logic [FILL_W-1:0]  text_fill_r, text_fill_nxt;
  byte_t              text_store_r [TEXT_LEN];
  byte_t              text_store_nxt [TEXT_LEN];
  logic               time_active_r, time_active_nxt;
  logic [TFILL_W-1:0] time_fill_r, time_fill_nxt;
  phase_t             scan_phase_r, scan_phase_nxt;
  logic               field_negative_r, field_negative_nxt;
  value_t             field_value_r, field_value_nxt;
  logic [4:0]         held_hours_r, held_hours_nxt;
  logic [5:0]         held_minutes_r, held_minutes_nxt;
  logic               range_ok_r, range_ok_nxt;

  // Result register
  logic       out_valid_r;
  byte_t      echo_r;
  logic       text_done_r, text_done_nxt;
  byte_t      char_r   [NUM_CHARS];
  byte_t      char_nxt [NUM_CHARS];
  logic       time_set_r, time_set_nxt;
  logic [4:0] hours_r, hours_nxt;
  logic [5:0] minutes_r, minutes_nxt;
  logic [5:0] seconds_r, seconds_nxt;

  logic   in_accept;
  byte_t  c;
  logic   is_digit;
  logic   is_space;
  logic [3:0]  digit;
  logic [27:0] mac;
  value_t      mac_sat;
  logic [1:0]  kind;
  byte_t       text_view [NUM_CHARS];

  function automatic logic in_limit(input logic neg, input value_t v, input value_t limit);
    logic ok;
    ok = !(neg && (v != '0)) && (v < limit);
    return ok;
  endfunction

  function automatic logic [1:0] phase_kind(input phase_t ph);
    logic [1:0] k;
    case (ph)
      4'd0, 4'd3, 4'd6: k = KIND_SPACE;
      4'd1, 4'd4, 4'd7: k = KIND_SIGN;
      default:          k = KIND_DIGITS;
    endcase
    return k;
  endfunction

  // Take a new request whenever the result register is free or being drained.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  assign c        = in_rx_byte;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign digit    = c[3:0];
  assign kind     = phase_kind(scan_phase_r);

  // value * 10 + digit by shift-add, saturated to 24 bits
  assign mac     = ({4'b0, field_value_r} << 3) + ({4'b0, field_value_r} << 1) + {24'b0, digit};
  assign mac_sat = (mac[27:24] != 4'b0) ? VALUE_MAX : mac[23:0];

  // Text store as seen after the closing '>' zeroes the fill position.
  for (genvar j = 0; j < NUM_CHARS; j++) begin : g_view
    if (j < TEXT_LEN) begin : g_live
      assign text_view[j] = (text_fill_r == FILL_W'(j)) ? '0 : text_store_r[j];
    end else begin : g_dead
      assign text_view[j] = '0;
    end
  end

  always_comb begin
    text_active_nxt    = text_active_r;
    text_fill_nxt      = text_fill_r;
    text_store_nxt     = text_store_r;
    time_active_nxt    = time_active_r;
    time_fill_nxt      = time_fill_r;
    scan_phase_nxt     = scan_phase_r;
    field_negative_nxt = field_negative_r;
    field_value_nxt    = field_value_r;
    held_hours_nxt     = held_hours_r;
    held_minutes_nxt   = held_minutes_r;
    range_ok_nxt       = range_ok_r;

    text_done_nxt = 1'b0;
    for (int j = 0; j < NUM_CHARS; j++) begin
      char_nxt[j] = '0;
    end
    time_set_nxt = 1'b0;
    hours_nxt    = '0;
    minutes_nxt  = '0;
    seconds_nxt  = '0;

    if (c == CH_LT) begin
      // Start a capture, cancel any time line.
      text_active_nxt    = 1'b1;
      text_fill_nxt      = '0;
      time_active_nxt    = 1'b0;
      time_fill_nxt      = '0;
      scan_phase_nxt     = '0;
      field_negative_nxt = 1'b0;
      field_value_nxt    = '0;
      held_hours_nxt     = '0;
      held_minutes_nxt   = '0;
      range_ok_nxt       = 1'b1;
    end else if (text_active_r) begin
      if (c == CH_GT) begin
        text_active_nxt = 1'b0;
        for (int i = 0; i < TEXT_LEN; i++) begin
          if (text_fill_r == FILL_W'(i)) begin
            text_store_nxt[i] = '0;
          end
        end
        text_done_nxt = 1'b1;
        for (int j = 0; j < NUM_CHARS; j++) begin
          char_nxt[j] = text_view[j];
        end
      end else if (text_fill_r < FILL_W'(TEXT_LEN)) begin
        for (int i = 0; i < TEXT_LEN; i++) begin
          if (text_fill_r == FILL_W'(i)) begin
            text_store_nxt[i] = c;
          end
        end
        text_fill_nxt = FILL_W'(text_fill_r + 1'b1);
      end
    end else if (c == CH_BANG) begin
      // Start or restart a time line.
      time_active_nxt    = 1'b1;
      text_fill_nxt      = '0;
      time_fill_nxt      = '0;
      scan_phase_nxt     = '0;
      field_negative_nxt = 1'b0;
      field_value_nxt    = '0;
      held_hours_nxt     = '0;
      held_minutes_nxt   = '0;
      range_ok_nxt       = 1'b1;
    end else if (time_active_r) begin
      if (c == CH_CR || c == CH_LF) begin
        time_active_nxt = 1'b0;
        if ((scan_phase_r == PH_LAST_DIGITS || scan_phase_r == PH_DONE) && range_ok_r &&
            in_limit(field_negative_r, field_value_r, MINSEC_LIMIT)) begin
          time_set_nxt = 1'b1;
          hours_nxt    = held_hours_r;
          minutes_nxt  = held_minutes_r;
          seconds_nxt  = field_value_r[5:0];
        end
        time_fill_nxt      = '0;
        scan_phase_nxt     = '0;
        field_negative_nxt = 1'b0;
        field_value_nxt    = '0;
        held_hours_nxt     = '0;
        held_minutes_nxt   = '0;
        range_ok_nxt       = 1'b1;
      end else if (time_fill_r < TFILL_W'(TIME_LINE_LEN)) begin
        time_fill_nxt = TFILL_W'(time_fill_r + 1'b1);
        if (scan_phase_r < PH_DONE) begin
          if (kind == KIND_SPACE) begin
            // Skip leading space, then take a sign or the first digit.
            if (!is_space) begin
              field_value_nxt    = '0;
              field_negative_nxt = 1'b0;
              if (c == CH_PLUS || c == CH_MINUS) begin
                field_negative_nxt = (c == CH_MINUS);
                scan_phase_nxt     = scan_phase_r + 4'd1;
              end else if (is_digit) begin
                field_value_nxt = {20'b0, digit};
                scan_phase_nxt  = scan_phase_r + 4'd2;
              end else begin
                scan_phase_nxt = PH_FAIL;
              end
            end
          end else if (is_digit) begin
            field_value_nxt = mac_sat;
            if (kind == KIND_SIGN) begin
              scan_phase_nxt = scan_phase_r + 4'd1;
            end
          end else if (kind == KIND_SIGN) begin
            scan_phase_nxt = PH_FAIL;
          end else if (scan_phase_r == PH_LAST_DIGITS) begin
            scan_phase_nxt = PH_DONE;
          end else if (c != CH_COLON) begin
            scan_phase_nxt = PH_FAIL;
          end else begin
            // Close hours or minutes at the colon.
            if (scan_phase_r == PH_HOUR_DIGITS) begin
              if (!in_limit(field_negative_r, field_value_r, HOUR_LIMIT)) begin
                range_ok_nxt = 1'b0;
              end
              held_hours_nxt = field_value_r[4:0];
            end else begin
              if (!in_limit(field_negative_r, field_value_r, MINSEC_LIMIT)) begin
                range_ok_nxt = 1'b0;
              end
              held_minutes_nxt = field_value_r[5:0];
            end
            scan_phase_nxt = scan_phase_r + 4'd1;
          end
        end
      end
    end
  end

  // Parser state: advance on each accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_active_r    <= 1'b0;
      text_fill_r      <= '0;
      for (int i = 0; i < TEXT_LEN; i++) begin
        text_store_r[i] <= '0;
      end
      time_active_r    <= 1'b0;
      time_fill_r      <= '0;
      scan_phase_r     <= '0;
      field_negative_r <= 1'b0;
      field_value_r    <= '0;
      held_hours_r     <= '0;
      held_minutes_r   <= '0;
      range_ok_r       <= 1'b1;
    end else if (in_accept) begin
      text_active_r    <= text_active_nxt;
      text_fill_r      <= text_fill_nxt;
      text_store_r     <= text_store_nxt;
      time_active_r    <= time_active_nxt;
      time_fill_r      <= time_fill_nxt;
      scan_phase_r     <= scan_phase_nxt;
      field_negative_r <= field_negative_nxt;
      field_value_r    <= field_value_nxt;
      held_hours_r     <= held_hours_nxt;
      held_minutes_r   <= held_minutes_nxt;
      range_ok_r       <= range_ok_nxt;
    end
  end

  // Result valid: set on accept, drop when taken with nothing new behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      echo_r      <= c;
      text_done_r <= text_done_nxt;
      char_r      <= char_nxt;
      time_set_r  <= time_set_nxt;
      hours_r     <= hours_nxt;
      minutes_r   <= minutes_nxt;
      seconds_r   <= seconds_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_echo_byte   = echo_r;
  assign out_text_done   = text_done_r;
  assign out_text_char_a = char_r[0];
  assign out_text_char_b = char_r[1];
  assign out_text_char_c = char_r[2];
  assign out_time_set    = time_set_r;
  assign out_hours       = hours_r;
  assign out_minutes     = minutes_r;
  assign out_seconds     = seconds_r;

  // Checks
  a_modes_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(text_active_r && time_active_r))
    else $error("text capture and time line active together");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(text_done_r && time_set_r))
    else $error("text_done and time_set in one result");

  a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && time_set_r) |-> (hours_r < 5'd24 && minutes_r < 6'd60 && seconds_r < 6'd60))
    else $error("time result out of range");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted request produced no result");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    scan_phase_r <= PH_FAIL)
    else $error("scan phase beyond fail code");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the serial text and time command parser
// Drives received bytes over the valid/ready request channel, predicts the
// echo, text capture and time scan result of every request, and checks each
// result field by field under random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import uttcp_pkg::*;

  localparam int TEXT_LEN      = 3;
  localparam int TIME_LINE_LEN = 11;

  // Blank characters that the scan skips but the package does not name.
  localparam byte_t CH_VT = 8'h0B;
  localparam byte_t CH_FF = 8'h0C;

  localparam int HOLD_CYCLES = 400;  // long receiver hold-off
  localparam int TAIL_CYCLES = 20;   // quiet stretch after the last result
  localparam int MAX_REPORTS = 10;

  // One result as seen on the out_ ports.
  typedef struct packed {
    byte_t      echo_byte;
    logic       text_done;
    byte_t      text_char_a;
    byte_t      text_char_b;
    byte_t      text_char_c;
    logic       time_set;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } parse_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the parser state, queues the predicted result of
  // every accepted request and checks results in order.
  // --------------------------------------------------------------------------
  class parse_scoreboard;
    bit            text_active;
    int            text_fill;
    byte_t         text_store [TEXT_LEN];
    bit            time_active;
    int            time_fill;
    phase_t        scan_phase;
    bit            field_negative;
    logic [31:0]   field_value;
    logic [4:0]    held_hours;
    logic [5:0]    held_minutes;
    bit            range_ok;

    parse_result_t expected_q[$];
    int            mismatches;
    int            checked;
    int            texts_closed;
    int            times_set;

    function void reset_state();
      text_active = 0;
      text_fill   = 0;
      foreach (text_store[i]) text_store[i] = '0;
      time_active = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      time_fill      = 0;
      scan_phase     = '0;
      field_negative = 0;
      field_value    = '0;
      held_hours     = '0;
      held_minutes   = '0;
      range_ok       = 1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // A negative value is only acceptable as zero.
    function bit within_limit(logic [31:0] lim);
      if (field_negative && field_value != 0) return 0;
      return field_value < lim;
    endfunction

    function bit is_blank(byte_t c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
             c == CH_FF || c == CH_CR;
    endfunction

    // Advance the "%d:%d:%d" scan by one byte.
    function void scan_step(byte_t c);
      logic [1:0] kind;
      bit         digit;
      digit = (c >= CH_ZERO && c <= CH_NINE);
      if (scan_phase >= PH_DONE) return;
      kind = 2'(scan_phase % 3);
      if (kind == KIND_SPACE) begin
        if (is_blank(c)) return;
        field_value    = '0;
        field_negative = 0;
        if (c == CH_PLUS || c == CH_MINUS) begin
          field_negative = (c == CH_MINUS);
          scan_phase     = scan_phase + 4'd1;
          return;
        end
        if (digit) begin
          field_value = 32'(c - CH_ZERO);
          scan_phase  = scan_phase + 4'd2;
          return;
        end
        scan_phase = PH_FAIL;
        return;
      end
      if (digit) begin
        field_value = field_value * 10 + 32'(c - CH_ZERO);
        if (field_value > 32'(VALUE_MAX)) field_value = 32'(VALUE_MAX);
        if (kind == KIND_SIGN) scan_phase = scan_phase + 4'd1;
        return;
      end
      if (kind == KIND_SIGN) begin
        scan_phase = PH_FAIL;
        return;
      end
      if (scan_phase == PH_LAST_DIGITS) begin
        scan_phase = PH_DONE;
        return;
      end
      if (c != CH_COLON) begin
        scan_phase = PH_FAIL;
        return;
      end
      if (scan_phase == PH_HOUR_DIGITS) begin
        if (!within_limit(32'(HOUR_LIMIT))) range_ok = 0;
        held_hours = field_value[4:0];
      end else begin
        if (!within_limit(32'(MINSEC_LIMIT))) range_ok = 0;
        held_minutes = field_value[5:0];
      end
      scan_phase = scan_phase + 4'd1;
    endfunction

    function parse_result_t predict(byte_t c);
      parse_result_t r;
      r           = '0;
      r.echo_byte = c;
      if (c == CH_LT) begin
        text_active = 1;
        text_fill   = 0;
        time_active = 0;
        clear_scan();
        return r;
      end
      if (text_active) begin
        if (c == CH_GT) begin
          text_active = 0;
          if (text_fill < TEXT_LEN) text_store[text_fill] = '0;
          r.text_done   = 1;
          r.text_char_a = text_store[0];
          r.text_char_b = text_store[1];
          r.text_char_c = text_store[2];
          texts_closed++;
          return r;
        end
        if (text_fill < TEXT_LEN) begin
          text_store[text_fill] = c;
          text_fill++;
        end
        return r;
      end
      if (c == CH_BANG) begin
        time_active = 1;
        clear_scan();
        text_fill = 0;
        return r;
      end
      if (time_active) begin
        if (c == CH_CR || c == CH_LF) begin
          time_active = 0;
          if ((scan_phase == PH_LAST_DIGITS || scan_phase == PH_DONE) && range_ok &&
              within_limit(32'(MINSEC_LIMIT))) begin
            r.time_set = 1;
            r.hours    = held_hours;
            r.minutes  = held_minutes;
            r.seconds  = field_value[5:0];
            times_set++;
          end
          clear_scan();
          return r;
        end
        if (time_fill < TIME_LINE_LEN) begin
          time_fill++;
          scan_step(c);
        end
      end
      return r;
    endfunction

    function void note_request(byte_t c);
      expected_q.push_back(predict(c));
    endfunction

    function bit field_ok(string name, logic [7:0] want, logic [7:0] got);
      if (want === got) return 1;
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch in result %0d, %s: expected 0x%02h, got 0x%02h",
                 checked, name, want, got);
      return 0;
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t want;
      bit            ok;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result, echo 0x%02h, with no request pending",
                   got.echo_byte);
        return;
      end
      want = expected_q.pop_front();
      ok = field_ok("echo_byte", want.echo_byte, got.echo_byte);
      ok = field_ok("text_done", 8'(want.text_done), 8'(got.text_done)) && ok;
      ok = field_ok("text_char_a", want.text_char_a, got.text_char_a) && ok;
      ok = field_ok("text_char_b", want.text_char_b, got.text_char_b) && ok;
      ok = field_ok("text_char_c", want.text_char_c, got.text_char_c) && ok;
      ok = field_ok("time_set", 8'(want.time_set), 8'(got.time_set)) && ok;
      ok = field_ok("hours", 8'(want.hours), 8'(got.hours)) && ok;
      ok = field_ok("minutes", 8'(want.minutes), 8'(got.minutes)) && ok;
      ok = field_ok("seconds", 8'(want.seconds), 8'(got.seconds)) && ok;
      checked++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_echo_byte;
  logic       out_text_done;
  logic [7:0] out_text_char_a;
  logic [7:0] out_text_char_b;
  logic [7:0] out_text_char_c;
  logic       out_time_set;
  logic [4:0] out_hours;
  logic [5:0] out_minutes;
  logic [5:0] out_seconds;

  uart_text_and_time_command_parser #(
    .TEXT_LEN      (TEXT_LEN),
    .TIME_LINE_LEN (TIME_LINE_LEN)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_echo_byte   (out_echo_byte),
    .out_text_done   (out_text_done),
    .out_text_char_a (out_text_char_a),
    .out_text_char_b (out_text_char_b),
    .out_text_char_c (out_text_char_c),
    .out_time_set    (out_time_set),
    .out_hours       (out_hours),
    .out_minutes     (out_minutes),
    .out_seconds     (out_seconds)
  );

  parse_scoreboard sb;
  parse_result_t   seen_result;
  int              send_idle_pct;  // chance per cycle that the sender idles
  int              recv_idle_pct;  // chance per cycle that the receiver stalls
  int              sent;           // requests accepted so far
  bit              hold_req;       // ask the receiver for a long hold-off
  int              hold_left;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Give up after a generous fixed time; a correct run ends far earlier.
  initial begin
    #3_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // Receiver: drive out_ready at the falling edge. A hold-off request takes
  // precedence over random stalls and is counted down here, so the sender
  // keeps offering requests while the block backs up.
  initial begin
    out_ready = 0;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: take every result at the rising edge where it is accepted.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_result = '{out_echo_byte, out_text_done, out_text_char_a, out_text_char_b,
                      out_text_char_c, out_time_set, out_hours, out_minutes,
                      out_seconds};
      sb.check_result(seen_result);
    end
  end

  // --------------------------------------------------------------------------
  // Request drivers. Every task starts and ends at a falling edge; the valid
  // line stays high between back-to-back requests and drops only on idles.
  // --------------------------------------------------------------------------
  task automatic send_byte(input byte_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid   = 1;
    in_rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Accepted at this edge: record the prediction before the result can show.
    sb.note_request(b);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Pause the sender until every predicted result has been taken.
  task automatic wait_for_drain();
    in_valid = 0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Text capture: '<', a short body (never '<' or '>'), sometimes a restart,
  // mostly closed by '>'.
  task automatic send_text_message();
    int    n;
    byte_t b;
    send_byte(CH_LT);
    n = $urandom_range(0, 5);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0: b = CH_BANG;
        1: b = $urandom_range(0, 1) ? CH_CR : CH_LF;
        2: b = 8'h00;
        default: begin
          b = byte_t'($urandom_range(0, 255));
          while (b == CH_LT || b == CH_GT) b = byte_t'($urandom_range(0, 255));
        end
      endcase
      send_byte(b);
    end
    if ($urandom_range(0, 9) == 0) begin
      // Restart the capture: old bytes stay in the store and may show as stale.
      send_byte(CH_LT);
      if ($urandom_range(0, 1)) send_byte(byte_t'($urandom_range(8'h61, 8'h7A)));
    end
    if ($urandom_range(0, 9) != 0) send_byte(CH_GT);
  endtask

  // One number of a time line: rare blanks, signs, leading zeros, missing
  // digits and oversized values; mostly a plain value up to top.
  task automatic send_number(input int top);
    int pick;
    int v;
    pick = $urandom_range(0, 19);
    if ($urandom_range(0, 7) == 0) send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    if (pick == 0) send_byte(CH_MINUS);
    if (pick == 1) send_byte(CH_PLUS);
    if (pick == 2) return;
    if (pick == 0) v = $urandom_range(0, 2);         // negative zero among them
    else if (pick == 3) v = $urandom_range(100, 99999999);
    else v = $urandom_range(0, top);
    if (pick == 4) send_byte(CH_ZERO);
    send_text($sformatf("%0d", v));
  endtask

  task automatic send_separator();
    case ($urandom_range(0, 39))
      0: send_byte(8'h00);                           // embedded zero ends the scan
      1: send_byte(byte_t'($urandom_range(0, 255)));
      2: send_byte(CH_SPACE);
      default: send_byte(CH_COLON);
    endcase
  endtask

  // Time line: '!' h:m:s, sometimes with trailing bytes or an interruption,
  // mostly ended by CR or LF.
  task automatic send_time_line();
    send_byte(CH_BANG);
    send_number(26);
    send_separator();
    send_number(62);
    send_separator();
    send_number(62);
    case ($urandom_range(0, 15))
      0: send_byte(byte_t'($urandom_range(0, 255)));
      1: send_text("xyz");
      2: send_byte(CH_LT);
      3: send_byte(CH_BANG);
      default: ;
    endcase
    if ($urandom_range(0, 9) != 0) send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase_end [3];
    int pick;
    bit hold_done;
    sb = new;
    sb.reset_state();
    in_valid      = 0;
    in_rx_byte    = '0;
    rst_n         = 0;
    send_idle_pct = 28;
    recv_idle_pct = 68;
    hold_req      = 0;
    hold_done     = 0;
    sent          = 0;
    phase_end     = '{600, 1200, 1750};
    repeat (8) @(negedge clk);
    rst_n = 1;

    // Directed: byte extremes and a stray '>', a short text, a full capture
    // holding '!', CR and LF with one byte dropped, an empty capture that
    // reports stale bytes, and a time line at the top of every range.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_GT);
    send_text("<ab>");
    send_text("<!");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_text("z>");
    send_text("<>");
    send_text("!23:59:59");
    send_byte(CH_CR);
    wait_for_drain();

    // Random: mostly receiver stalls, then mostly sender idles, then full speed with one
    // long receiver hold-off. Drain between phases.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 68 : 0;
      recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 28 : 0;
      while (sent < phase_end[phase]) begin
        if (phase == 2 && !hold_done && sent > 1400) begin
          hold_req  = 1;
          hold_done = 1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 35) send_text_message();
        else if (pick < 80) send_time_line();
        else repeat ($urandom_range(1, 4)) send_byte(byte_t'($urandom_range(0, 255)));
      end
      wait_for_drain();
    end

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("run covered %0d requests and %0d checked results", sent, sb.checked);
    $display("  including %0d closed text captures and %0d accepted time lines",
             sb.texts_closed, sb.times_set);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/uttcp_pkg.sv
hw/rtl/uart_text_and_time_command_parser.sv
tb/tb.sv
